@@ design/snr_pkg.sv @@
// -----------------------------------------------------------------------------
// snr_pkg
// Shared constants and sideband types for the Snell refraction pipeline.
// -----------------------------------------------------------------------------
package snr_pkg;

	localparam int VEC_FRAC = 14;             // Q2.14 vectors
	localparam int IDX_FRAC = 12;             // Q4.12 index

	localparam int ETA_W    = 27;             // eta <= 2^26
	localparam int C_W      = VEC_FRAC + 1;   // cos i, 0..2^14
	localparam int ECR_W    = 28;             // round(eta*c) <= 2^26
	localparam int RAD_W    = 2 * C_W;        // sqrt radicand
	localparam int DIV_STAGES = 9;
	localparam int DIV_BPS    = 3;            // quotient bits per stage
	localparam int SQ_STAGES  = 5;
	localparam int SQ_BPS     = 3;            // root bits per stage

	localparam logic signed [15:0] NEG_ONE = -16'sd16384;

	// carried alongside the divider
	typedef struct packed {
		logic signed [15:0] ix;
		logic signed [15:0] iy;
		logic signed [15:0] iz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               entering;
		logic [C_W-1:0]     c;
		logic [17:0]        eta_leave;
	} div_side_t;

	// carried alongside the square root
	typedef struct packed {
		logic signed [15:0] ix;
		logic signed [15:0] iy;
		logic signed [15:0] iz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               entering;
		logic [ETA_W-1:0]   eta;
		logic [ECR_W-1:0]   ecr;
		logic               tir;
	} sq_side_t;

endpackage

@@ design/snr_div.sv @@
// -----------------------------------------------------------------------------
// snr_div
// Pipelined restoring divider, 27-bit quotient over a 16-bit divisor.
// -----------------------------------------------------------------------------
module snr_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic [snr_pkg::ETA_W-1:0] num,
	input  logic [15:0]             den,
	input  snr_pkg::div_side_t      side_in,
	output logic                    out_vld,
	output logic [snr_pkg::ETA_W-1:0] quo,
	output snr_pkg::div_side_t      side_out
);
	localparam int N = snr_pkg::DIV_STAGES;
	localparam int W = snr_pkg::ETA_W;

	logic [W-1:0]       num_s  [0:N];
	logic [W-1:0]       quo_s  [0:N];
	logic [15:0]        rem_s  [0:N];
	logic [15:0]        den_s  [0:N];
	snr_pkg::div_side_t side_s [0:N];
	logic [N:0]         vld_s;

	assign num_s[0]  = num;
	assign quo_s[0]  = '0;
	assign rem_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_vld;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [W-1:0] n_nxt;
		logic [W-1:0] q_nxt;
		logic [15:0]  r_nxt;

		always_comb begin
			logic [16:0] r;
			n_nxt = num_s[g];
			q_nxt = quo_s[g];
			r_nxt = rem_s[g];
			for (int b = 0; b < snr_pkg::DIV_BPS; b++) begin
				r     = {r_nxt, n_nxt[W-1]};
				n_nxt = {n_nxt[W-2:0], 1'b0};
				if (r >= {1'b0, den_s[g]}) begin
					r     = r - {1'b0, den_s[g]};
					q_nxt = {q_nxt[W-2:0], 1'b1};
				end else begin
					q_nxt = {q_nxt[W-2:0], 1'b0};
				end
				r_nxt = r[15:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[g+1]  <= n_nxt;
				quo_s[g+1]  <= q_nxt;
				rem_s[g+1]  <= r_nxt;
				den_s[g+1]  <= den_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign quo      = quo_s[N];
	assign side_out = side_s[N];

endmodule

@@ design/snr_sqrt.sv @@
// -----------------------------------------------------------------------------
// snr_sqrt
// Pipelined digit-by-digit integer square root, 15-bit root.
// -----------------------------------------------------------------------------
module snr_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [snr_pkg::RAD_W-1:0] rad,
	input  snr_pkg::sq_side_t         side_in,
	output logic                      out_vld,
	output logic [snr_pkg::C_W-1:0]   root,
	output snr_pkg::sq_side_t         side_out
);
	localparam int N  = snr_pkg::SQ_STAGES;
	localparam int RW = snr_pkg::RAD_W;
	localparam int QW = snr_pkg::C_W;

	logic [RW-1:0]     rad_s  [0:N];
	logic [QW-1:0]     root_s [0:N];
	logic [QW+2:0]     rem_s  [0:N];
	snr_pkg::sq_side_t side_s [0:N];
	logic [N:0]        vld_s;

	assign rad_s[0]  = rad;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_vld;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [RW-1:0] a_nxt;
		logic [QW-1:0] q_nxt;
		logic [QW+2:0] r_nxt;

		always_comb begin
			logic [QW+2:0] r;
			logic [QW+2:0] trial;
			a_nxt = rad_s[g];
			q_nxt = root_s[g];
			r_nxt = rem_s[g];
			for (int b = 0; b < snr_pkg::SQ_BPS; b++) begin
				r     = {r_nxt[QW:0], a_nxt[RW-1:RW-2]};
				a_nxt = {a_nxt[RW-3:0], 2'b00};
				trial = {1'b0, q_nxt, 2'b01};
				if (r >= trial) begin
					r     = r - trial;
					q_nxt = {q_nxt[QW-2:0], 1'b1};
				end else begin
					q_nxt = {q_nxt[QW-2:0], 1'b0};
				end
				r_nxt = r;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1]  <= a_nxt;
				root_s[g+1] <= q_nxt;
				rem_s[g+1]  <= r_nxt;
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign root     = root_s[N];
	assign side_out = side_s[N];

endmodule

@@ design/snell_refraction_vector.sv @@
// -----------------------------------------------------------------------------
// snell_refraction_vector
// Refracts a Q2.14 direction through a surface of Q4.12 index (Snell's law).
// -----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  in      | in_valid  | in_stall  | incident_x/y/z, normal_x/y/z,
//          |           |           | refractive_index
//  out     | out_valid | out_stall | refracted_x/y/z, total_reflection
//
//  One transfer in per cycle while in_stall is low; the pipeline includes
//  the 9-stage divider (1/index, 3 quotient bits a stage)
//  and the 5-stage square root (3 root bits a stage).
//  The whole pipeline advances together; it freezes only while a finished
//  result sits at the output and out_stall is high, so in_stall follows that.
//  arst_n clears the valid bits only; data registers are not reset.
//
//  Stages: s1 products of I.N | s2 sum, clamp, cos i | s3..s11 divide
//  s12 eta^2, eta*c, c^2 | s13 eta^2*(1-c^2) | s14 k, reflection test
//  s15..s19 sqrt | s20 m | s21 I*eta, n*m | s22 round, add, saturate
// -----------------------------------------------------------------------------
module snell_refraction_vector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] incident_x,
	input  logic signed [15:0] incident_y,
	input  logic signed [15:0] incident_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic [15:0]        refractive_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] refracted_x,
	output logic signed [15:0] refracted_y,
	output logic signed [15:0] refracted_z,
	output logic               total_reflection
);
	localparam int F   = snr_pkg::VEC_FRAC;
	localparam int EW  = snr_pkg::ETA_W;
	localparam int CW  = snr_pkg::C_W;
	localparam int RW  = snr_pkg::ECR_W;

	// global advance: hold everything only while the output is blocked
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---------------- s1: component products ----------------
	logic               v_s1;
	logic signed [15:0] ix_s1, iy_s1, iz_s1, nx_s1, ny_s1, nz_s1;
	logic [15:0]        idx_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s1  <= incident_x;
			iy_s1  <= incident_y;
			iz_s1  <= incident_z;
			nx_s1  <= normal_x;
			ny_s1  <= normal_y;
			nz_s1  <= normal_z;
			// zero index behaves as one lsb
			idx_s1 <= (refractive_index == 16'd0) ? 16'd1 : refractive_index;
			px_s1  <= incident_x * normal_x;
			py_s1  <= incident_y * normal_y;
			pz_s1  <= incident_z * normal_z;
		end
	end

	// ---------------- s2: dot product, clamp, cos i ----------------
	localparam logic signed [33:0] DOT_LIM = 34'sd1 <<< (2 * F);

	logic signed [33:0] dot_w, dotc_w;
	logic               ent_w;
	logic [29:0]        absd_w;
	logic [29:0]        crnd_w;

	always_comb begin
		dot_w = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		if (dot_w > DOT_LIM)
			dotc_w = DOT_LIM;
		else if (dot_w < -DOT_LIM)
			dotc_w = -DOT_LIM;
		else
			dotc_w = dot_w;
		ent_w  = dotc_w[33];
		absd_w = ent_w ? 30'(-dotc_w) : 30'(dotc_w);
		crnd_w = absd_w + 30'(1 << (F - 1));
	end

	logic                v_s2;
	logic [EW-1:0]       num_s2;
	logic [15:0]         den_s2;
	snr_pkg::div_side_t  side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2            <= EW'(1 << (snr_pkg::IDX_FRAC + F)) + EW'(idx_s1 >> 1);
			den_s2            <= idx_s1;
			side_s2.ix        <= ix_s1;
			side_s2.iy        <= iy_s1;
			side_s2.iz        <= iz_s1;
			side_s2.nx        <= nx_s1;
			side_s2.ny        <= ny_s1;
			side_s2.nz        <= nz_s1;
			side_s2.entering  <= ent_w;
			side_s2.c         <= crnd_w[F+CW-1:F];
			// leaving: index * 2^F / 2^12 is exact
			side_s2.eta_leave <= {idx_s1, 2'b00};
		end
	end

	// ---------------- s3..s11: eta = 2^26 / index ----------------
	logic               v_s11;
	logic [EW-1:0]      quo_s11;
	snr_pkg::div_side_t side_s11;

	snr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s2),
		.num      (num_s2),
		.den      (den_s2),
		.side_in  (side_s2),
		.out_vld  (v_s11),
		.quo      (quo_s11),
		.side_out (side_s11)
	);

	// ---------------- s12: eta^2, eta*c, c^2 ----------------
	logic [EW-1:0] eta_w;
	logic [29:0]   ccr_w;
	assign eta_w = side_s11.entering ? quo_s11 : EW'(side_s11.eta_leave);
	assign ccr_w = 30'(side_s11.c) * 30'(side_s11.c) + 30'(1 << (F - 1));

	logic               v_s12;
	logic [EW-1:0]      eta_s12;
	logic [53:0]        ee_s12;
	logic [41:0]        ec_s12;
	logic [CW-1:0]      s_s12;
	snr_pkg::div_side_t side_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			eta_s12  <= eta_w;
			ee_s12   <= 54'(eta_w) * 54'(eta_w);
			ec_s12   <= 42'(eta_w) * 42'(side_s11.c);
			s_s12    <= CW'(1 << F) - ccr_w[F+CW-1:F];
			side_s12 <= side_s11;
		end
	end

	// ---------------- s13: eta^2 * (1 - c^2) ----------------
	logic [53:0] eer_w;
	logic [41:0] ecr_w;
	assign eer_w = ee_s12 + 54'(1 << (F - 1));
	assign ecr_w = ec_s12 + 42'(1 << (F - 1));

	logic               v_s13;
	logic [EW-1:0]      eta_s13;
	logic [54:0]        tp_s13;
	logic [RW-1:0]      ecr_s13;
	snr_pkg::div_side_t side_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			eta_s13  <= eta_s12;
			tp_s13   <= 55'(eer_w[53:F]) * 55'(s_s12);
			ecr_s13  <= ecr_w[F+RW-1:F];
			side_s13 <= side_s12;
		end
	end

	// ---------------- s14: k = 1 - t, reflection test ----------------
	logic [55:0]   tr_w;
	logic [41:0]   t_w;
	logic          tir_w;
	logic [CW-1:0] k_w;
	assign tr_w  = 56'(tp_s13) + 56'(1 << (F - 1));
	assign t_w   = tr_w[55:F];
	assign tir_w = t_w > 42'(1 << F);
	assign k_w   = CW'(1 << F) - t_w[CW-1:0];

	logic                     v_s14;
	logic [snr_pkg::RAD_W-1:0] rad_s14;
	snr_pkg::sq_side_t        sside_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s14            <= {1'b0, k_w, F'(0)};
			sside_s14.ix       <= side_s13.ix;
			sside_s14.iy       <= side_s13.iy;
			sside_s14.iz       <= side_s13.iz;
			sside_s14.nx       <= side_s13.nx;
			sside_s14.ny       <= side_s13.ny;
			sside_s14.nz       <= side_s13.nz;
			sside_s14.entering <= side_s13.entering;
			sside_s14.eta      <= eta_s13;
			sside_s14.ecr      <= ecr_s13;
			sside_s14.tir      <= tir_w;
		end
	end

	// ---------------- s15..s19: sqrt(k * 2^F) ----------------
	logic              v_s19;
	logic [CW-1:0]     sq_s19;
	snr_pkg::sq_side_t sside_s19;

	snr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s14),
		.rad      (rad_s14),
		.side_in  (sside_s14),
		.out_vld  (v_s19),
		.root     (sq_s19),
		.side_out (sside_s19)
	);

	// ---------------- s20: m = eta*c - sqrt k ----------------
	logic               v_s20;
	logic signed [28:0] m_s20;
	snr_pkg::sq_side_t  sside_s20;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s20     <= $signed({1'b0, sside_s19.ecr}) - $signed({14'd0, sq_s19});
			sside_s20 <= sside_s19;
		end
	end

	// ---------------- s21: I*eta and n*m ----------------
	logic signed [27:0] etas_w;
	logic signed [16:0] nx_w, ny_w, nz_w;
	assign etas_w = $signed({1'b0, sside_s20.eta});
	// leaving the material flips the normal
	assign nx_w = sside_s20.entering ? 17'(sside_s20.nx) : -17'(sside_s20.nx);
	assign ny_w = sside_s20.entering ? 17'(sside_s20.ny) : -17'(sside_s20.ny);
	assign nz_w = sside_s20.entering ? 17'(sside_s20.nz) : -17'(sside_s20.nz);

	logic               v_s21;
	logic signed [43:0] ax_s21, ay_s21, az_s21;
	logic signed [45:0] bx_s21, by_s21, bz_s21;
	logic               tir_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s21  <= 44'(sside_s20.ix) * 44'(etas_w);
			ay_s21  <= 44'(sside_s20.iy) * 44'(etas_w);
			az_s21  <= 44'(sside_s20.iz) * 44'(etas_w);
			bx_s21  <= 46'(nx_w) * 46'(m_s20);
			by_s21  <= 46'(ny_w) * 46'(m_s20);
			bz_s21  <= 46'(nz_w) * 46'(m_s20);
			tir_s21 <= sside_s20.tir;
		end
	end

	// ---------------- s22: round, add, saturate ----------------
	function automatic logic signed [15:0] snr_out(
		input logic signed [43:0] a,
		input logic signed [45:0] b
	);
		logic signed [43:0] ar;
		logic signed [45:0] br;
		logic signed [32:0] sum;
		ar  = (a + 44'sd8192) >>> 14;
		br  = (b + 46'sd8192) >>> 14;
		sum = 33'(ar) + 33'(br);
		if (sum > 33'sd32767)
			return 16'sh7fff;
		else if (sum < -33'sd32768)
			return 16'sh8000;
		else
			return sum[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			refracted_x      <= tir_s21 ? snr_pkg::NEG_ONE : snr_out(ax_s21, bx_s21);
			refracted_y      <= tir_s21 ? snr_pkg::NEG_ONE : snr_out(ay_s21, by_s21);
			refracted_z      <= tir_s21 ? snr_pkg::NEG_ONE : snr_out(az_s21, bz_s21);
			total_reflection <= tir_s21;
		end
	end

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s12     <= 1'b0;
			v_s13     <= 1'b0;
			v_s14     <= 1'b0;
			v_s20     <= 1'b0;
			v_s21     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s12     <= v_s11;
			v_s13     <= v_s12;
			v_s14     <= v_s13;
			v_s20     <= v_s19;
			v_s21     <= v_s20;
			out_valid <= v_s21;
		end
	end

	// ---------------- checks ----------------
	a_tir_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_reflection |->
			refracted_x == snr_pkg::NEG_ONE && refracted_y == snr_pkg::NEG_ONE &&
			refracted_z == snr_pkg::NEG_ONE)
		else $error("reflection result not -1");

	a_eta_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s12 |-> eta_s12 <= EW'(1 << (snr_pkg::IDX_FRAC + F)))
		else $error("eta out of range");

	a_rad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s14 && !sside_s14.tir |-> rad_s14 <= snr_pkg::RAD_W'(1 << (2 * F)))
		else $error("sqrt radicand out of range");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s12) && $stable(eta_s12) && $stable(m_s20))
		else $error("pipeline moved while frozen");

endmodule
